### sv/shb_pkg.sv
// ============================================================================
// shb_pkg: shared types and constants for the string hash block
// Hash constants, register indexes and the opcodes of the shared multiplier.
// ============================================================================
package shb_pkg;

    // MurmurHash3 x86_32 constants
    localparam logic [31:0] MM_C1 = 32'hcc9e_2d51;
    localparam logic [31:0] MM_C2 = 32'h1b87_3593;
    localparam logic [31:0] MM_N  = 32'he654_6b64;
    localparam logic [31:0] MM_F1 = 32'h85eb_ca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2_ae35;

    // Bucket modulus, largest prime below 2^16
    localparam logic [16:0] BUCKET_MOD = 17'h0_fff1;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_USE_MURMUR = 1'b0;
    localparam logic REG_HASH_SEED  = 1'b1;

    // Operations of the shared multiplier
    typedef enum logic [1:0] {
        MUL_K1,     // k * C1
        MUL_K2,     // rotl(k, 15) * C2
        MUL_FIN1,   // (h ^ h >> 16) * F1
        MUL_FIN2    // (h ^ h >> 13) * F2
    } mul_op_t;

endpackage : shb_pkg

### sv/shb_mul.sv
// ============================================================================
// shb_mul: shared 32x32 multiplier of the hash datapath
// Applies the operand premix of each hash step, then a modulo 2^32 multiply
// by the matching constant.
// ============================================================================
module shb_mul (
    input  shb_pkg::mul_op_t op,
    input  logic [31:0]      operand,
    output logic [31:0]      product
);

    logic [31:0] mul_a;
    logic [31:0] mul_b;

    // Operand premix and constant select
    always_comb
    begin
        unique case (op)
            shb_pkg::MUL_K1:
            begin
                mul_a = operand;
                mul_b = shb_pkg::MM_C1;
            end
            shb_pkg::MUL_K2:
            begin
                mul_a = {operand[16:0], operand[31:17]};
                mul_b = shb_pkg::MM_C2;
            end
            shb_pkg::MUL_FIN1:
            begin
                mul_a = operand ^ {16'd0, operand[31:16]};
                mul_b = shb_pkg::MM_F1;
            end
            shb_pkg::MUL_FIN2:
            begin
                mul_a = operand ^ {13'd0, operand[31:13]};
                mul_b = shb_pkg::MM_F2;
            end
            default:
            begin
                mul_a = operand;
                mul_b = shb_pkg::MM_C1;
            end
        endcase
    end

    // Low 32 bits of the product
    assign product = mul_a * mul_b;

endmodule : shb_mul

### sv/string_hash_bucket_index.sv
// ============================================================================
// string_hash_bucket_index: byte-stream string hash and bucket index
// Per byte: MurmurHash3 x86_32 or multiply-by-33 rolling hash; on the last
// byte, the 32-bit hash and hash mod 65521 are returned.
// ============================================================================
// Byte path: a byte that does not complete a 4-byte block is absorbed directly; a
// byte that completes a block goes through two multiplies and a mix step (K1, K2, MIX).
// Closing item: FIN, K1, K2 and MIX on a partial tail, F1 to F3, R1 and R2
// (FIN, R1, R2 in rolling mode); the final multiplies and the tail scramble all
// go through one shared multiplier. Throughput: one item in flight; byte_stall
// stays high until it is done. Reset: control state and both registers clear.
module string_hash_bucket_index (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte channel
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    // hash channel
    output logic        hash_valid,
    input  logic        hash_stall,
    output logic [15:0] bucket,
    output logic [31:0] full_hash
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_MIX,
        ST_FIN,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_R1,
        ST_R2,
        ST_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic        use_murmur_reg, use_murmur_next;
    logic [31:0] hash_seed_reg, hash_seed_next;
    logic [31:0] running_reg, running_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] length_reg, length_next;
    logic        at_start_reg, at_start_next;
    logic        last_reg, last_next;
    logic        tail_reg, tail_next;
    logic [31:0] work_reg, work_next;
    logic [19:0] red_reg, red_next;
    logic        hash_valid_reg, hash_valid_next;
    logic [15:0] bucket_reg, bucket_next;
    logic [31:0] full_hash_reg, full_hash_next;

    logic             cfg_write;
    logic             byte_take;
    shb_pkg::mul_op_t mul_op;
    logic [31:0]      mul_product;

    // String-start view of the state
    logic [31:0] h0;
    logic [23:0] pw0;
    logic [1:0]  ph0;
    logic [31:0] len0;
    logic [31:0] sext_byte;
    logic [31:0] mix_rot;
    logic [16:0] red_fold;

    // Shared multiplier
    shb_mul u_mul (
        .op      (mul_op),
        .operand (work_reg),
        .product (mul_product)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_K1:   mul_op = shb_pkg::MUL_K1;
            ST_K2:   mul_op = shb_pkg::MUL_K2;
            ST_F1:   mul_op = shb_pkg::MUL_FIN1;
            ST_F2:   mul_op = shb_pkg::MUL_FIN2;
            default: mul_op = shb_pkg::MUL_K1;
        endcase
    end

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            shb_pkg::REG_USE_MURMUR: prdata = {31'd0, use_murmur_reg};
            shb_pkg::REG_HASH_SEED:  prdata = hash_seed_reg;
            default:                 prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        use_murmur_next = use_murmur_reg;
        hash_seed_next  = hash_seed_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                shb_pkg::REG_USE_MURMUR: use_murmur_next = pwdata[0];
                shb_pkg::REG_HASH_SEED:  hash_seed_next  = pwdata;
                default:                 use_murmur_next = use_murmur_reg;
            endcase
        end
    end

    // Handshake
    assign byte_stall = (state_reg != ST_IDLE);
    assign byte_take  = byte_valid && !byte_stall && (has_byte || last);
    assign hash_valid = hash_valid_reg;
    assign bucket     = bucket_reg;
    assign full_hash  = full_hash_reg;

    // State as seen by the accepted byte
    always_comb
    begin
        if (at_start_reg)
        begin
            h0   = use_murmur_reg ? hash_seed_reg : 32'd0;
            pw0  = 24'd0;
            ph0  = 2'd0;
            len0 = 32'd0;
        end
        else
        begin
            h0   = running_reg;
            pw0  = partial_reg;
            ph0  = phase_reg;
            len0 = length_reg;
        end
    end

    assign sext_byte = {{24{data_byte[7]}}, data_byte};

    // Block mix: rotl(h ^ k, 13), then * 5 + N as shift-add
    assign mix_rot = {running_reg[18:0] ^ work_reg[18:0], running_reg[31:19] ^ work_reg[31:19]};

    // Second fold of the mod 65521 reduction (2^16 = 15 mod 65521)
    assign red_fold = {1'b0, red_reg[15:0]} + ({13'd0, red_reg[19:16]} << 4)
                      - {13'd0, red_reg[19:16]};

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        partial_next    = partial_reg;
        phase_next      = phase_reg;
        length_next     = length_reg;
        at_start_next   = at_start_reg;
        last_next       = last_reg;
        tail_next       = tail_reg;
        work_next       = work_reg;
        red_next        = red_reg;
        hash_valid_next = hash_valid_reg;
        bucket_next     = bucket_reg;
        full_hash_next  = full_hash_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_take)
                begin
                    at_start_next = 1'b0;
                    last_next     = last;
                    tail_next     = 1'b0;
                    running_next  = h0;
                    partial_next  = pw0;
                    phase_next    = ph0;
                    length_next   = len0 + {31'd0, has_byte};
                    state_next    = last ? ST_FIN : ST_IDLE;
                    if (has_byte)
                    begin
                        if (!use_murmur_reg)
                        begin
                            running_next = sext_byte + {h0[26:0], 5'd0} + h0;
                        end
                        else if (ph0 == 2'd3)
                        begin
                            work_next    = {data_byte, pw0};
                            partial_next = 24'd0;
                            phase_next   = 2'd0;
                            state_next   = ST_K1;
                        end
                        else
                        begin
                            case (ph0)
                                2'd0:    partial_next = {pw0[23:8], data_byte};
                                2'd1:    partial_next = {pw0[23:16], data_byte, pw0[7:0]};
                                default: partial_next = {data_byte, pw0[15:0]};
                            endcase
                            phase_next = ph0 + 2'd1;
                        end
                    end
                end
            end
            ST_K1:
            begin
                work_next  = mul_product;
                state_next = ST_K2;
            end
            ST_K2:
            begin
                work_next  = mul_product;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (tail_reg)
                begin
                    work_next  = running_reg ^ work_reg ^ length_reg;
                    state_next = ST_F1;
                end
                else
                begin
                    running_next = {mix_rot[29:0], 2'd0} + mix_rot + shb_pkg::MM_N;
                    state_next   = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (!use_murmur_reg)
                begin
                    work_next  = running_reg;
                    state_next = ST_R1;
                end
                else if (phase_reg != 2'd0)
                begin
                    work_next  = {8'd0, partial_reg};
                    tail_next  = 1'b1;
                    state_next = ST_K1;
                end
                else
                begin
                    work_next  = running_reg ^ length_reg;
                    state_next = ST_F1;
                end
            end
            ST_F1:
            begin
                work_next  = mul_product;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                work_next  = mul_product;
                state_next = ST_F3;
            end
            ST_F3:
            begin
                work_next  = work_reg ^ {16'd0, work_reg[31:16]};
                state_next = ST_R1;
            end
            ST_R1:
            begin
                // first fold: hi * 15 + lo, below 2^20
                red_next   = {4'd0, work_reg[15:0]} + ({4'd0, work_reg[31:16]} << 4)
                             - {4'd0, work_reg[31:16]};
                state_next = ST_R2;
            end
            ST_R2:
            begin
                if (red_fold >= shb_pkg::BUCKET_MOD)
                begin
                    bucket_next = 16'(red_fold - shb_pkg::BUCKET_MOD);
                end
                else
                begin
                    bucket_next = red_fold[15:0];
                end
                full_hash_next  = work_reg;
                hash_valid_next = 1'b1;
                at_start_next   = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (!hash_stall)
                begin
                    hash_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            use_murmur_reg <= 1'b0;
            hash_seed_reg  <= 32'd0;
            running_reg    <= 32'd0;
            partial_reg    <= 24'd0;
            phase_reg      <= 2'd0;
            length_reg     <= 32'd0;
            at_start_reg   <= 1'b1;
            last_reg       <= 1'b0;
            tail_reg       <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            use_murmur_reg <= use_murmur_next;
            hash_seed_reg  <= hash_seed_next;
            running_reg    <= running_next;
            partial_reg    <= partial_next;
            phase_reg      <= phase_next;
            length_reg     <= length_next;
            at_start_reg   <= at_start_next;
            last_reg       <= last_next;
            tail_reg       <= tail_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        red_reg       <= red_next;
        bucket_reg    <= bucket_next;
        full_hash_reg <= full_hash_next;
    end

endmodule : string_hash_bucket_index
